>>> hdl/z80alu_pkg.sv
// ----------------------------------------------------------------------------
// z80alu_pkg
// Shared types, flag bit positions and the DAA correction table of the
// Z80-style ALU.
// ----------------------------------------------------------------------------
package z80alu_pkg;

   // operation selector codes
   typedef enum logic [4:0] {
      OP_ADD   = 5'd0,
      OP_ADC   = 5'd1,
      OP_SUB   = 5'd2,
      OP_SBC   = 5'd3,
      OP_AND   = 5'd4,
      OP_OR    = 5'd5,
      OP_XOR   = 5'd6,
      OP_INC   = 5'd7,
      OP_DEC   = 5'd8,
      OP_RLC   = 5'd9,
      OP_RRC   = 5'd10,
      OP_RL    = 5'd11,
      OP_RR    = 5'd12,
      OP_SLA   = 5'd13,
      OP_SRA   = 5'd14,
      OP_SLL   = 5'd15,
      OP_SRL   = 5'd16,
      OP_BIT   = 5'd17,
      OP_SET   = 5'd18,
      OP_RES   = 5'd19,
      OP_DAA   = 5'd20,
      OP_ADD16 = 5'd21,
      OP_ADC16 = 5'd22,
      OP_SBC16 = 5'd23,
      OP_RLD   = 5'd24,
      OP_RRD   = 5'd25
   } alu_op_type;

   // flag byte bit positions: S Z 5 H 3 PV N C
   localparam int F_C  = 0;
   localparam int F_N  = 1;
   localparam int F_PV = 2;
   localparam int F_3  = 3;
   localparam int F_H  = 4;
   localparam int F_5  = 5;
   localparam int F_Z  = 6;
   localparam int F_S  = 7;

   // ADD16 takes 5 H 3 N C from the high byte add, keeps S Z PV
   localparam logic [7:0] ADD16_NEW_MASK = 8'h3B;
   localparam logic [7:0] ADD16_OLD_MASK = 8'hC4;

   // DAA correction, row = {C, H}, column = nibble class
   localparam logic [0:3][0:5][7:0] DAA_ADJ = {
      8'h00, 8'h06, 8'h00, 8'h66, 8'h60, 8'h66,
      8'h06, 8'h06, 8'h06, 8'h66, 8'h66, 8'h66,
      8'h60, 8'h66, 8'h60, 8'h66, 8'h60, 8'h66,
      8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66
   };

   typedef struct packed {
      alu_op_type  op;
      logic [15:0] operand_a;
      logic [15:0] operand_b;
      logic [7:0]  flags_in;
      logic [2:0]  bit_pos;
      logic        full_flags;
   } alu_req_type;

   typedef struct packed {
      logic [15:0] result;
      logic [7:0]  second_byte;
      logic [7:0]  flags_out;
   } alu_rsp_type;

endpackage

>>> hdl/z80alu_core.sv
// ----------------------------------------------------------------------------
// z80alu_core
// Combinational datapath: one ALU operation with its result, write-back
// byte and new flags.
// ----------------------------------------------------------------------------
module z80alu_core (
   input  z80alu_pkg::alu_req_type req,
   output z80alu_pkg::alu_rsp_type rsp
);
   import z80alu_pkg::*;

   // returns {flags, result}
   function automatic logic [15:0] arith8(input logic [7:0] a, input logic [7:0] b,
                                          input logic cin, input logic sub);
      logic [8:0] r;
      logic [7:0] f;
      r = sub ? ({1'b0, a} - {1'b0, b} - {8'd0, cin})
              : ({1'b0, a} + {1'b0, b} + {8'd0, cin});
      f       = '0;
      f[F_C]  = r[8];
      f[F_N]  = sub;
      f[F_H]  = a[4] ^ b[4] ^ r[4];
      f[F_PV] = sub ? ((a[7] ^ b[7]) & (r[7] ^ a[7]))
                    : (~(a[7] ^ b[7]) & (r[7] ^ a[7]));
      f[F_Z]  = (r[7:0] == 8'h00);
      f[F_S]  = r[7];
      f[F_5]  = r[5];
      f[F_3]  = r[3];
      return {f, r[7:0]};
   endfunction

   function automatic logic [7:0] szp53(input logic [7:0] fi, input logic [7:0] v);
      logic [7:0] f;
      f       = fi;
      f[F_S]  = v[7];
      f[F_Z]  = (v == 8'h00);
      f[F_5]  = v[5];
      f[F_3]  = v[3];
      f[F_PV] = ~(^v);
      return f;
   endfunction

   function automatic logic [7:0] rot_flags(input logic [7:0] fi, input logic [7:0] v,
                                            input logic c, input logic full);
      logic [7:0] f;
      f      = fi;
      f[F_C] = c;
      f[F_H] = 1'b0;
      f[F_N] = 1'b0;
      f[F_5] = v[5];
      f[F_3] = v[3];
      if (full) begin
         f = szp53(f, v);
      end
      return f;
   endfunction

   logic [7:0]  a8;
   logic [7:0]  b8;
   logic [7:0]  fin;
   logic        cy;
   logic [15:0] ar8;
   logic [15:0] lo16;
   logic [15:0] hi16;
   logic        sub16;
   logic [3:0]  lo_nib;
   logic [3:0]  hi_nib;
   logic [2:0]  daa_cls;
   logic [7:0]  daa_corr;
   logic [7:0]  bit_mask;
   logic [7:0]  r8;
   logic [15:0] r16;
   logic [7:0]  sec;
   logic [7:0]  f;

   assign a8  = req.operand_a[7:0];
   assign b8  = req.operand_b[7:0];
   assign fin = req.flags_in;
   assign cy  = fin[F_C];

   // 8-bit add/sub: bit0 of the code selects carry in, bit1 selects subtract
   assign ar8 = arith8(a8, b8, req.op[0] & cy, req.op[1]);

   // 16-bit add/sub as two chained byte adds
   assign sub16 = (req.op == OP_SBC16);
   assign lo16  = arith8(a8, b8, (req.op != OP_ADD16) & cy, sub16);
   assign hi16  = arith8(req.operand_a[15:8], req.operand_b[15:8], lo16[8 + F_C], sub16);

   assign lo_nib   = a8[3:0];
   assign hi_nib   = a8[7:4];
   assign daa_cls  = {hi_nib > 4'd9, hi_nib == 4'd9, lo_nib > 4'd9};
   assign daa_corr = DAA_ADJ[{fin[F_C], fin[F_H]}][daa_cls];

   assign bit_mask = 8'd1 << req.bit_pos;

   always_comb begin
      r8  = 8'h00;
      r16 = 16'h0000;
      sec = 8'h00;
      f   = fin;
      case (req.op)
         OP_ADD, OP_ADC, OP_SUB, OP_SBC: begin
            r8 = ar8[7:0];
            f  = ar8[15:8];
         end
         OP_AND: begin
            r8     = a8 & b8;
            f      = szp53(8'h00, r8);
            f[F_H] = 1'b1;
         end
         OP_OR: begin
            r8 = a8 | b8;
            f  = szp53(8'h00, r8);
         end
         OP_XOR: begin
            r8 = a8 ^ b8;
            f  = szp53(8'h00, r8);
         end
         OP_INC: begin
            r8      = a8 + 8'd1;
            f       = 8'h00;
            f[F_C]  = cy;
            f[F_PV] = (a8 == 8'h7F);
            f[F_H]  = (r8[3:0] == 4'h0);
            f[F_S]  = r8[7];
            f[F_5]  = r8[5];
            f[F_3]  = r8[3];
            f[F_Z]  = (r8 == 8'h00);
         end
         OP_DEC: begin
            r8      = a8 - 8'd1;
            f       = 8'h00;
            f[F_C]  = cy;
            f[F_N]  = 1'b1;
            f[F_PV] = (a8 == 8'h80);
            f[F_H]  = (r8[3:0] == 4'hF);
            f[F_S]  = r8[7];
            f[F_5]  = r8[5];
            f[F_3]  = r8[3];
            f[F_Z]  = (r8 == 8'h00);
         end
         OP_RLC: begin
            r8 = {a8[6:0], a8[7]};
            f  = rot_flags(fin, r8, a8[7], req.full_flags);
         end
         OP_RRC: begin
            r8 = {a8[0], a8[7:1]};
            f  = rot_flags(fin, r8, a8[0], req.full_flags);
         end
         OP_RL: begin
            r8 = {a8[6:0], cy};
            f  = rot_flags(fin, r8, a8[7], req.full_flags);
         end
         OP_RR: begin
            r8 = {cy, a8[7:1]};
            f  = rot_flags(fin, r8, a8[0], req.full_flags);
         end
         OP_SLA: begin
            r8 = {a8[6:0], 1'b0};
            f  = rot_flags(fin, r8, a8[7], 1'b1);
         end
         OP_SRA: begin
            r8 = {a8[7], a8[7:1]};
            f  = rot_flags(fin, r8, a8[0], 1'b1);
         end
         OP_SLL: begin
            r8 = {a8[6:0], 1'b1};
            f  = rot_flags(fin, r8, a8[7], 1'b1);
         end
         OP_SRL: begin
            r8 = {1'b0, a8[7:1]};
            f  = rot_flags(fin, r8, a8[0], 1'b1);
         end
         OP_BIT: begin
            r8     = a8;
            f      = 8'h00;
            f[F_C] = cy;
            f[F_H] = 1'b1;
            f[F_5] = a8[5];
            f[F_3] = a8[3];
            if (a8[req.bit_pos]) begin
               f[F_S] = (req.bit_pos == 3'd7);
            end else begin
               f[F_Z]  = 1'b1;
               f[F_PV] = 1'b1;
            end
         end
         OP_SET: begin
            r8 = a8 | bit_mask;
         end
         OP_RES: begin
            r8 = a8 & ~bit_mask;
         end
         OP_DAA: begin
            r8     = fin[F_N] ? (a8 - daa_corr) : (a8 + daa_corr);
            f      = 8'h00;
            f[F_N] = fin[F_N];
            f[F_C] = (daa_cls >= 3'd3) | cy;
            f[F_H] = fin[F_N] ? (fin[F_H] & (lo_nib <= 4'd5)) : (lo_nib > 4'd9);
            f      = szp53(f, r8);
         end
         OP_ADD16, OP_ADC16, OP_SBC16: begin
            r16    = {hi16[7:0], lo16[7:0]};
            f      = hi16[15:8];
            f[F_Z] = (r16 == 16'h0000);
            f[F_S] = r16[15];
            if (req.op == OP_ADD16) begin
               f = (f & ADD16_NEW_MASK) | (fin & ADD16_OLD_MASK);
            end
         end
         OP_RLD: begin
            r8     = {a8[7:4], b8[7:4]};
            sec    = {b8[3:0], a8[3:0]};
            f      = 8'h00;
            f[F_C] = cy;
            f      = szp53(f, r8);
         end
         OP_RRD: begin
            r8     = {a8[7:4], b8[3:0]};
            sec    = {a8[3:0], b8[7:4]};
            f      = 8'h00;
            f[F_C] = cy;
            f      = szp53(f, r8);
         end
         default: begin
            r8 = 8'h00;
         end
      endcase
   end

   assign rsp.result      = ((req.op == OP_ADD16) || (req.op == OP_ADC16) ||
                             (req.op == OP_SBC16)) ? r16 : {8'h00, r8};
   assign rsp.second_byte = sec;
   assign rsp.flags_out   = f;

endmodule

>>> hdl/z80_alu_with_flags_unit.sv
// ----------------------------------------------------------------------------
// z80_alu_with_flags_unit
// Z80-style 8/16-bit ALU with full flag generation, registered in and out.
// ----------------------------------------------------------------------------
// Usage: drive an operation on the req_ ports with start high; it is
// transferred at that clock edge since busy is always low, so a new
// operation may be issued every cycle. Each transfer yields exactly one
// result, shown on the rsp_ ports with rsp_valid high for a single cycle.
// Each operation passes the input register, one pass of combinational ALU
// logic and the result register. The receiver cannot stall: results must
// be captured in the cycle that rsp_valid is high. Results come out in
// issue order. Flags follow the S Z 5 H 3 PV N C layout, including the
// undocumented bits 5 and 3; PV is the result's parity for logic ops,
// DAA, RLD/RRD and full-flag shifts, and overflow for 8-bit arithmetic.
// rsp_second_byte carries the memory byte for RLD/RRD and is zero
// otherwise. There is no state kept between operations.
// ----------------------------------------------------------------------------
module z80_alu_with_flags_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [4:0]  req_type,
   input  logic [15:0] req_operand_a,
   input  logic [15:0] req_operand_b,
   input  logic [7:0]  req_flags_in,
   input  logic [2:0]  req_bit_pos,
   input  logic        req_full_flags,
   output logic        rsp_valid,
   output logic [15:0] rsp_result,
   output logic [7:0]  rsp_second_byte,
   output logic [7:0]  rsp_flags_out
);
   import z80alu_pkg::*;

   // input stage
   logic        req_valid_ff;
   logic        req_valid_in;
   alu_req_type req_ff;
   alu_req_type req_in;

   // output stage
   logic        rsp_valid_ff;
   alu_rsp_type rsp_ff;
   alu_rsp_type rsp_in;

   // single-pass datapath never backs up
   assign busy = 1'b0;

   assign req_valid_in       = start & ~busy;
   assign req_in.op          = alu_op_type'(req_type);
   assign req_in.operand_a   = req_operand_a;
   assign req_in.operand_b   = req_operand_b;
   assign req_in.flags_in    = req_flags_in;
   assign req_in.bit_pos     = req_bit_pos;
   assign req_in.full_flags  = req_full_flags;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   // payload: capture only on a transfer, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_ff <= req_in;
      end
      if (req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   z80alu_core u_core (
      .req (req_ff),
      .rsp (rsp_in)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result      = rsp_ff.result;
   assign rsp_second_byte = rsp_ff.second_byte;
   assign rsp_flags_out   = rsp_ff.flags_out;

endmodule

>>> hdl/z80alu_checker.sv
// ----------------------------------------------------------------------------
// z80alu_checker
// Port-level checks of the ALU unit: transfer-to-result matching and per-operation output rules.
// ----------------------------------------------------------------------------
module z80alu_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [4:0]  req_type,
   input logic [7:0]  req_flags_in,
   input logic        rsp_valid,
   input logic [15:0] rsp_result,
   input logic [7:0]  rsp_second_byte,
   input logic [7:0]  rsp_flags_out
);
   import z80alu_pkg::*;

   // every transfer yields a result after the input and result registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("missing result two cycles after transfer");

   // no result without a matching earlier transfer
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without matching transfer");

   // SET and RES leave flags alone
   a_setres_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ($past(req_type, 2) == OP_SET || $past(req_type, 2) == OP_RES))
      |-> (rsp_flags_out == $past(req_flags_in, 2)))
      else $error("SET/RES changed flags");

   // write-back byte only for RLD/RRD
   a_second_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_type, 2) != OP_RLD && $past(req_type, 2) != OP_RRD)
      |-> (rsp_second_byte == 8'h00))
      else $error("second byte nonzero outside RLD/RRD");

   // high result byte is zero except for 16-bit operations
   a_high_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_type, 2) != OP_ADD16 && $past(req_type, 2) != OP_ADC16 &&
       $past(req_type, 2) != OP_SBC16)
      |-> (rsp_result[15:8] == 8'h00))
      else $error("high result byte nonzero on 8-bit operation");

endmodule

bind z80_alu_with_flags_unit z80alu_checker u_checker (.*);

>>> tb/tb_z80_alu_with_flags_unit.sv
// ----------------------------------------------------------------------------
// tb_z80_alu_with_flags_unit
// Self-checking bench for the Z80-style ALU. A short table of directed
// operations is followed by random ones. Each transfer is scored against a
// bit-exact flag predictor, or against a hand-typed result on a few rows.
// ----------------------------------------------------------------------------
module tb_z80_alu_with_flags_unit;
   import z80alu_pkg::*;

   // selector codes past OP_RRD decode to nothing
   localparam logic [4:0] SEL_FIRST_UNUSED = 5'd26;
   localparam logic [4:0] SEL_LAST_CODE    = 5'd31;

   localparam int RANDOM_OPS     = 1825;
   localparam int IDLE_PERCENT   = 34;
   localparam int NO_IDLE_FROM   = 500;   // random ops in this window never idle
   localparam int NO_IDLE_TO     = 900;
   localparam int DRAIN_AT       = 1300;  // sender waits for an empty pipe here
   localparam int TAIL_CYCLES    = 4;
   localparam int WATCHDOG_LIMIT = 500;

   // one operation plus an optional hand-typed answer
   typedef struct packed {
      logic [4:0]  sel;
      logic [15:0] a;
      logic [15:0] b;
      logic [7:0]  fl;
      logic [2:0]  bp;
      logic        full;
      logic        fixed;
      alu_rsp_type rsp;
   } alu_cmd_type;

   typedef struct packed {
      logic [4:0]  sel;
      alu_rsp_type rsp;
   } alu_due_type;

   typedef struct packed {
      logic [7:0] val;
      logic [7:0] fl;
   } byte_flags_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [4:0]  req_type;
   logic [15:0] req_operand_a;
   logic [15:0] req_operand_b;
   logic [7:0]  req_flags_in;
   logic [2:0]  req_bit_pos;
   logic        req_full_flags;
   logic        rsp_valid;
   logic [15:0] rsp_result;
   logic [7:0]  rsp_second_byte;
   logic [7:0]  rsp_flags_out;

   // side channel that rides along with the request ports
   logic        typed_valid;
   alu_rsp_type typed_rsp;

   alu_due_type alu_results_due[$];
   alu_cmd_type directed_ops[$];

   int error_count;
   int issued_count;
   int checked_count;
   int quiet_cycles;
   bit sel_seen[32];

   z80_alu_with_flags_unit uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_operand_a   (req_operand_a),
      .req_operand_b   (req_operand_b),
      .req_flags_in    (req_flags_in),
      .req_bit_pos     (req_bit_pos),
      .req_full_flags  (req_full_flags),
      .rsp_valid       (rsp_valid),
      .rsp_result      (rsp_result),
      .rsp_second_byte (rsp_second_byte),
      .rsp_flags_out   (rsp_flags_out)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Flag predictor
   // ------------------------------------------------------------------------

   // S Z PV 5 3 from a byte, everything else in f kept
   function automatic logic [7:0] with_szp(input logic [7:0] f, input logic [7:0] v);
      logic [7:0] g;
      g       = f;
      g[F_S]  = v[7];
      g[F_5]  = v[5];
      g[F_3]  = v[3];
      g[F_Z]  = (v == 8'h00);
      g[F_PV] = ~^v;     // even parity
      return g;
   endfunction

   // 8-bit add/sub with carry in; produces all eight flags
   function automatic byte_flags_type add_sub8(input logic [7:0] a, input logic [7:0] b,
                                               input logic cin, input logic sub);
      logic [8:0]     r;
      logic [4:0]     nib;
      byte_flags_type o;
      o.fl = 8'h00;
      if (sub) begin
         r          = {1'b0, a} - {1'b0, b} - {8'd0, cin};
         o.fl[F_N]  = 1'b1;
         o.fl[F_H]  = a[4] ^ b[4] ^ r[4];
         o.fl[F_PV] = (a[7] ^ b[7]) & (r[7] ^ a[7]);
      end else begin
         r          = {1'b0, a} + {1'b0, b} + {8'd0, cin};
         nib        = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
         o.fl[F_H]  = nib[4];
         o.fl[F_PV] = ~(a[7] ^ b[7]) & (r[7] ^ a[7]);
      end
      o.fl[F_C] = r[8];
      o.fl[F_Z] = (r[7:0] == 8'h00);
      o.fl[F_S] = r[7];
      o.fl[F_5] = r[5];
      o.fl[F_3] = r[3];
      o.val     = r[7:0];
      return o;
   endfunction

   // rotate/shift: C given, H N cleared, 5 3 from value, S Z PV optional
   function automatic logic [7:0] shift_flags(input logic [7:0] f, input logic [7:0] v,
                                              input logic c, input logic full);
      logic [7:0] g;
      g      = f;
      g[F_C] = c;
      g[F_H] = 1'b0;
      g[F_N] = 1'b0;
      g[F_5] = v[5];
      g[F_3] = v[3];
      if (full) g = with_szp(g, v);
      return g;
   endfunction

   function automatic alu_rsp_type z80_alu_result(input logic [4:0] sel,
                                                  input logic [15:0] a16,
                                                  input logic [15:0] b16,
                                                  input logic [7:0] fin,
                                                  input logic [2:0] bp,
                                                  input logic full);
      logic [7:0]     a, b, t8, f, adj;
      logic [3:0]     lo_nib, hi_nib;
      logic           fix_lo, fix_hi, wide;
      logic [15:0]    res16;
      byte_flags_type lo, hi;
      alu_rsp_type    o;
      a     = a16[7:0];
      b     = b16[7:0];
      t8    = 8'h00;
      f     = fin;
      wide  = 1'b0;
      res16 = 16'h0000;
      o.second_byte = 8'h00;
      case (sel)
         OP_ADD, OP_ADC, OP_SUB, OP_SBC: begin
            // sel[0] picks the carry-in form, sel[1] the subtract form
            lo = add_sub8(a, b, sel[0] & fin[F_C], sel[1]);
            t8 = lo.val;
            f  = lo.fl;
         end
         OP_AND, OP_OR, OP_XOR: begin
            t8 = (sel == OP_AND) ? (a & b) : (sel == OP_OR) ? (a | b) : (a ^ b);
            f  = with_szp(8'h00, t8);
            f[F_H] = (sel == OP_AND);
         end
         OP_INC, OP_DEC: begin
            f      = 8'h00;
            f[F_C] = fin[F_C];
            if (sel == OP_DEC) begin
               t8      = a - 8'd1;
               f[F_N]  = 1'b1;
               f[F_PV] = (a == 8'h80);
               f[F_H]  = (t8[3:0] == 4'hF);
            end else begin
               t8      = a + 8'd1;
               f[F_PV] = (a == 8'h7F);
               f[F_H]  = (t8[3:0] == 4'h0);
            end
            f[F_S] = t8[7];
            f[F_5] = t8[5];
            f[F_3] = t8[3];
            f[F_Z] = (t8 == 8'h00);
         end
         OP_RLC: begin t8 = {a[6:0], a[7]};     f = shift_flags(fin, t8, a[7], full); end
         OP_RRC: begin t8 = {a[0], a[7:1]};     f = shift_flags(fin, t8, a[0], full); end
         OP_RL:  begin t8 = {a[6:0], fin[F_C]}; f = shift_flags(fin, t8, a[7], full); end
         OP_RR:  begin t8 = {fin[F_C], a[7:1]}; f = shift_flags(fin, t8, a[0], full); end
         OP_SLA: begin t8 = {a[6:0], 1'b0};     f = shift_flags(fin, t8, a[7], 1'b1); end
         OP_SRA: begin t8 = {a[7], a[7:1]};     f = shift_flags(fin, t8, a[0], 1'b1); end
         OP_SLL: begin t8 = {a[6:0], 1'b1};     f = shift_flags(fin, t8, a[7], 1'b1); end
         OP_SRL: begin t8 = {1'b0, a[7:1]};     f = shift_flags(fin, t8, a[0], 1'b1); end
         OP_BIT: begin
            // byte passes through; 5 and 3 come from the tested byte itself
            t8     = a;
            f      = 8'h00;
            f[F_C] = fin[F_C];
            f[F_H] = 1'b1;
            f[F_5] = a[5];
            f[F_3] = a[3];
            if (a[bp]) begin
               f[F_S] = (bp == 3'd7);
            end else begin
               f[F_Z]  = 1'b1;
               f[F_PV] = 1'b1;
            end
         end
         OP_SET: t8 = a | (8'd1 << bp);
         OP_RES: t8 = a & ~(8'd1 << bp);
         OP_DAA: begin
            lo_nib = a[3:0];
            hi_nib = a[7:4];
            fix_lo = fin[F_H] | (lo_nib > 4'd9);
            fix_hi = fin[F_C] | (hi_nib > 4'd9) | ((hi_nib == 4'd9) & (lo_nib > 4'd9));
            adj    = {1'b0, fix_hi, fix_hi, 2'b00, fix_lo, fix_lo, 1'b0};
            t8     = fin[F_N] ? (a - adj) : (a + adj);
            f      = 8'h00;
            f[F_N] = fin[F_N];
            f[F_C] = fix_hi;
            if (!fin[F_N])
               f[F_H] = (lo_nib > 4'd9);
            else
               f[F_H] = fin[F_H] & (lo_nib <= 4'd5);
            f = with_szp(f, t8);
         end
         OP_ADD16, OP_ADC16, OP_SBC16: begin
            wide  = 1'b1;
            lo    = add_sub8(a16[7:0], b16[7:0], (sel != OP_ADD16) & fin[F_C],
                             sel == OP_SBC16);
            hi    = add_sub8(a16[15:8], b16[15:8], lo.fl[F_C], sel == OP_SBC16);
            res16 = {hi.val, lo.val};
            f      = hi.fl;
            f[F_Z] = (res16 == 16'h0000);
            f[F_S] = res16[15];
            if (sel == OP_ADD16) f = (f & ADD16_NEW_MASK) | (fin & ADD16_OLD_MASK);
         end
         OP_RLD, OP_RRD: begin
            if (sel == OP_RLD) begin
               t8            = {a[7:4], b[7:4]};
               o.second_byte = {b[3:0], a[3:0]};
            end else begin
               t8            = {a[7:4], b[3:0]};
               o.second_byte = {a[3:0], b[7:4]};
            end
            f      = with_szp(8'h00, t8);
            f[F_C] = fin[F_C];
         end
         default: begin
            t8 = 8'h00;
            f  = fin;
         end
      endcase
      o.result    = wide ? res16 : {8'h00, t8};
      o.flags_out = f;
      return o;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   function automatic alu_cmd_type alu_cmd(input logic [4:0] sel, input logic [15:0] a,
                                           input logic [15:0] b, input logic [7:0] fl,
                                           input logic [2:0] bp, input logic full);
      alu_cmd_type c;
      c.sel   = sel;
      c.a     = a;
      c.b     = b;
      c.fl    = fl;
      c.bp    = bp;
      c.full  = full;
      c.fixed = 1'b0;
      c.rsp   = '0;
      return c;
   endfunction

   // row whose answer is typed in by hand
   function automatic alu_cmd_type alu_cmd_typed(input logic [4:0] sel,
                                                 input logic [15:0] a,
                                                 input logic [15:0] b, input logic [7:0] fl,
                                                 input logic [2:0] bp, input logic [15:0] res,
                                                 input logic [7:0] sec, input logic [7:0] fo);
      alu_cmd_type c;
      c       = alu_cmd(sel, a, b, fl, bp, 1'b0);
      c.fixed = 1'b1;
      c.rsp   = {res, sec, fo};
      return c;
   endfunction

   function automatic alu_cmd_type random_cmd();
      alu_cmd_type c;
      logic [4:0]  sel;
      // a few percent land on the undecoded selector codes
      if ($urandom_range(99) < 4)
         sel = 5'($urandom_range(SEL_LAST_CODE, SEL_FIRST_UNUSED));
      else
         sel = 5'($urandom_range(OP_RRD, OP_ADD));
      c = alu_cmd(sel, 16'($urandom), 16'($urandom), 8'($urandom), 3'($urandom),
                  1'($urandom));
      return c;
   endfunction

   // random idle cycles ahead of a transfer; start also drops at the drain and at the end
   task automatic sender_idle(input bit allow);
      while (allow && ($urandom_range(99) < IDLE_PERCENT)) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // present one op and hold it until the transfer edge
   task automatic issue_op(input alu_cmd_type c);
      req_type       <= c.sel;
      req_operand_a  <= c.a;
      req_operand_b  <= c.b;
      req_flags_in   <= c.fl;
      req_bit_pos    <= c.bp;
      req_full_flags <= c.full;
      typed_valid    <= c.fixed;
      typed_rsp      <= c.rsp;
      start          <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // checked at the falling edge, away from the edge where the pipe moves
   task automatic wait_pipe_empty();
      while (alu_results_due.size() != 0) @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Scoreboard and watchdog: all sampling at the rising edge, where the
   // bench's own drives have not landed yet
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      alu_due_type due;
      bit          moved;
      moved = 1'b0;
      if (!reset && rsp_valid) begin
         moved = 1'b1;
         if (alu_results_due.size() == 0) begin
            $display("%0t: result with nothing outstanding: %h %h %h", $time,
                     rsp_result, rsp_second_byte, rsp_flags_out);
            error_count++;
         end else begin
            due = alu_results_due.pop_front();
            checked_count++;
            if (rsp_result !== due.rsp.result) begin
               $display("%0t: sel %0d result: expected %h actual %h", $time, due.sel,
                        due.rsp.result, rsp_result);
               error_count++;
            end
            if (rsp_second_byte !== due.rsp.second_byte) begin
               $display("%0t: sel %0d second_byte: expected %h actual %h", $time, due.sel,
                        due.rsp.second_byte, rsp_second_byte);
               error_count++;
            end
            if (rsp_flags_out !== due.rsp.flags_out) begin
               $display("%0t: sel %0d flags_out: expected %b actual %b", $time, due.sel,
                        due.rsp.flags_out, rsp_flags_out);
               error_count++;
            end
         end
      end
      // a transfer at this edge queues its expected answer
      if (!reset && start && !busy) begin
         moved   = 1'b1;
         due.sel = req_type;
         if (typed_valid)
            due.rsp = typed_rsp;
         else
            due.rsp = z80_alu_result(req_type, req_operand_a, req_operand_b, req_flags_in,
                                     req_bit_pos, req_full_flags);
         alu_results_due.push_back(due);
         sel_seen[req_type] = 1'b1;
         issued_count++;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("tb_z80_alu_with_flags_unit NOT OK");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      int sel_count;
      error_count    = 0;
      issued_count   = 0;
      checked_count  = 0;
      quiet_cycles   = 0;
      reset          = 1'b1;
      start          = 1'b0;
      req_type       = OP_ADD;
      req_operand_a  = 16'h0000;
      req_operand_b  = 16'h0000;
      req_flags_in   = 8'h00;
      req_bit_pos    = 3'd0;
      req_full_flags = 1'b0;
      typed_valid    = 1'b0;
      typed_rsp      = '0;

      // directed table: extremes, every op, each flag corner
      directed_ops.push_back(alu_cmd_typed(OP_ADD, 16'h0000, 16'h0000, 8'h00, 3'd0,
                                           16'h0000, 8'h00, 8'h40));
      directed_ops.push_back(alu_cmd_typed(OP_ADD, 16'hFFFF, 16'hFF01, 8'h00, 3'd0,
                                           16'h0000, 8'h00, 8'h51));
      directed_ops.push_back(alu_cmd(OP_ADC, 16'h007F, 16'h0000, 8'h01, 3'd0, 1'b0));
      directed_ops.push_back(alu_cmd_typed(OP_SUB, 16'h0080, 16'h0001, 8'h00, 3'd0,
                                           16'h007F, 8'h00, 8'h3E));
      directed_ops.push_back(alu_cmd(OP_SBC, 16'h0000, 16'h00FF, 8'hFF, 3'd7, 1'b1));
      directed_ops.push_back(alu_cmd(OP_AND, 16'hFFFF, 16'hFFFF, 8'h00, 3'd0, 1'b0));
      directed_ops.push_back(alu_cmd(OP_OR, 16'h0000, 16'h0000, 8'hFF, 3'd0, 1'b0));
      directed_ops.push_back(alu_cmd(OP_XOR, 16'h00AA, 16'h0055, 8'h00, 3'd0, 1'b0));
      directed_ops.push_back(alu_cmd_typed(OP_INC, 16'h007F, 16'h0000, 8'h00, 3'd0,
                                           16'h0080, 8'h00, 8'h94));
      directed_ops.push_back(alu_cmd_typed(OP_DEC, 16'h0080, 16'h0000, 8'h01, 3'd0,
                                           16'h007F, 8'h00, 8'h3F));
      // rotates with full_flags low keep S Z PV from the incoming flags
      directed_ops.push_back(alu_cmd(OP_RLC, 16'h0080, 16'h0000, 8'hC4, 3'd0, 1'b0));
      directed_ops.push_back(alu_cmd(OP_RRC, 16'h0001, 16'h0000, 8'h00, 3'd0, 1'b1));
      directed_ops.push_back(alu_cmd(OP_RL, 16'h00FF, 16'h0000, 8'h01, 3'd0, 1'b0));
      directed_ops.push_back(alu_cmd(OP_RR, 16'h0000, 16'h0000, 8'h01, 3'd0, 1'b1));
      directed_ops.push_back(alu_cmd(OP_SLA, 16'h0080, 16'h0000, 8'hFF, 3'd0, 1'b0));
      directed_ops.push_back(alu_cmd(OP_SRA, 16'h0081, 16'h0000, 8'h00, 3'd0, 1'b0));
      directed_ops.push_back(alu_cmd(OP_SLL, 16'h0000, 16'h0000, 8'h00, 3'd0, 1'b0));
      directed_ops.push_back(alu_cmd(OP_SRL, 16'h0001, 16'h0000, 8'h00, 3'd0, 1'b0));
      // BIT: tested byte passes through, 5 and 3 copied from it
      directed_ops.push_back(alu_cmd(OP_BIT, 16'h0028, 16'h0000, 8'h01, 3'd7, 1'b0));
      directed_ops.push_back(alu_cmd(OP_BIT, 16'h0080, 16'h0000, 8'h00, 3'd7, 1'b0));
      // SET/RES leave the flags alone
      directed_ops.push_back(alu_cmd_typed(OP_SET, 16'h0000, 16'h0000, 8'h5A, 3'd7,
                                           16'h0080, 8'h00, 8'h5A));
      directed_ops.push_back(alu_cmd_typed(OP_RES, 16'h00FF, 16'h0000, 8'h00, 3'd0,
                                           16'h00FE, 8'h00, 8'h00));
      directed_ops.push_back(alu_cmd(OP_DAA, 16'h009A, 16'h0000, 8'h00, 3'd0, 1'b0));
      directed_ops.push_back(alu_cmd(OP_DAA, 16'h0000, 16'h0000, 8'h13, 3'd0, 1'b0));
      // ADD16 keeps S Z PV
      directed_ops.push_back(alu_cmd(OP_ADD16, 16'hFFFF, 16'h0001, 8'hC4, 3'd0, 1'b0));
      directed_ops.push_back(alu_cmd(OP_ADC16, 16'h7FFF, 16'h0000, 8'h01, 3'd0, 1'b0));
      directed_ops.push_back(alu_cmd(OP_SBC16, 16'h0000, 16'hFFFF, 8'hFF, 3'd0, 1'b0));
      directed_ops.push_back(alu_cmd(OP_RLD, 16'h0012, 16'h0034, 8'h01, 3'd0, 1'b0));
      directed_ops.push_back(alu_cmd(OP_RRD, 16'h00F0, 16'h000F, 8'hFE, 3'd0, 1'b0));
      // undecoded selector: zero result, flags pass through
      directed_ops.push_back(alu_cmd_typed(SEL_LAST_CODE, 16'hFFFF, 16'hFFFF, 8'hA5, 3'd7,
                                           16'h0000, 8'h00, 8'hA5));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_ops[i]) begin
         sender_idle(1'b1);
         issue_op(directed_ops[i]);
      end

      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (n == DRAIN_AT) begin
            // hold off until the pipe has fully emptied
            start <= 1'b0;
            @(negedge clock);
            wait_pipe_empty();
            @(posedge clock);
         end
         sender_idle(n < NO_IDLE_FROM || n >= NO_IDLE_TO);
         issue_op(random_cmd());
      end

      start <= 1'b0;
      @(negedge clock);
      wait_pipe_empty();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (alu_results_due.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, alu_results_due.size());
         error_count++;
      end

      sel_count = 0;
      foreach (sel_seen[i]) sel_count += sel_seen[i];
      $display("Ran %0d ALU transfers (%0d from the directed table), %0d results scored,",
               issued_count, directed_ops.size(), checked_count);
      $display("%0d of 32 selector codes exercised, %0d mismatches.", sel_count, error_count);
      if (error_count == 0)
         $display("tb_z80_alu_with_flags_unit OK");
      else
         $display("tb_z80_alu_with_flags_unit NOT OK");
      $finish;
   end

endmodule

>>> sim.f
hdl/z80alu_pkg.sv
hdl/z80alu_core.sv
hdl/z80_alu_with_flags_unit.sv
hdl/z80alu_checker.sv
tb/tb_z80_alu_with_flags_unit.sv
